/* hdl/psc_pkg.sv */
// shared types, constants and helpers for the pressure sensor conditioner
package psc_pkg;

  localparam int MV_W       = 12;
  localparam int FUNC_W     = 2;
  localparam int PA_W       = 22;
  localparam int FAULT_W    = 2;
  localparam int SUPPLY_W   = 13;
  localparam int SPAN_W     = 10;
  localparam int FS_W       = 20;
  localparam int ZREAD_W    = 16;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int ZSUM_W     = 28;
  localparam int ZCNT_W     = 16;
  localparam int THEO_W     = 23;
  localparam int THEO_RW    = 24;
  localparam int THEO_PW    = THEO_W + THEO_RW;
  localparam int THEO_SHIFT = 34;
  localparam int DEN_W      = 23;
  localparam int PROD_W     = 32;
  localparam int PCT_W      = 20;
  localparam int DIV_DW     = 43;
  localparam int DIV_SW     = 23;
  localparam int DIV_NW     = $clog2(DIV_DW + 1);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [MV_W-1:0]     MV_MAX         = 12'd4095;
  localparam logic [MV_W-1:0]     LOW_MV         = 12'd50;
  localparam logic [SUPPLY_W:0]   NEAR_SUPPLY_MV = 14'd100;
  localparam logic [PCT_W-1:0]    PCT_SCALE      = 20'd100;
  localparam logic [PCT_W-1:0]    PCT_BIDIR      = 20'd30;
  localparam logic [PCT_W-1:0]    PCT_LOW        = 20'd3;
  localparam logic [PCT_W-1:0]    PCT_BAND_LO    = 20'd20;
  localparam logic [PCT_W-1:0]    PCT_BAND_HI    = 20'd40;
  localparam logic [PCT_W-1:0]    PCT_HIGH       = 20'd65;
  localparam logic [SPAN_W-1:0]   PERMILLE       = 10'd1000;
  // ceil(2^34 / 2000): exact division by 2000 for any 23-bit numerator
  localparam logic [THEO_RW-1:0]  THEO_RECIP     = 24'd8589935;
  localparam logic [THEO_W-1:0]   THEO_ROUND     = 23'd1000;
  localparam logic [10:0]         SCALE_UNI      = 11'd1000;
  localparam logic [10:0]         SCALE_BI       = 11'd2000;
  localparam logic [DIV_DW-1:0]   PA_LIMIT       = 43'd2000000;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_MEASURE = 2'd0,
    FUNC_ZERO    = 2'd1,
    FUNC_LOAD    = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SUPPLY        = 3'd0,
    REG_SPAN          = 3'd1,
    REG_FULL_SCALE    = 3'd2,
    REG_BIDIR         = 3'd3,
    REG_AUTO_DETECT   = 3'd4,
    REG_ZERO_READINGS = 3'd5
  } reg_idx_t;

  typedef enum logic [FAULT_W-1:0] {
    FAULT_OK   = 2'd0,
    FAULT_LOW  = 2'd1,
    FAULT_HIGH = 2'd2
  } fault_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_AVG_MUL,
    ST_AVG_SET,
    ST_CHECK,
    ST_ZDIV_GO,
    ST_ZDIV_WAIT,
    ST_DETECT,
    ST_EZ,
    ST_THEO_NUM,
    ST_THEO_SET,
    ST_MUL1,
    ST_MUL2,
    ST_PDIV_GO,
    ST_PDIV_WAIT,
    ST_OUT
  } back_state_t;

  typedef struct packed {
    logic [SUPPLY_W-1:0] supply_mv;
    logic [SPAN_W-1:0]   span_permille;
    logic [FS_W-1:0]     full_scale_pa;
    logic                auto_detect;
    logic [ZREAD_W-1:0]  zero_readings;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic value;
  } mode_load_t;

  // width of a group sum plus its rounding half, never narrower than a sample
  function automatic int sum_width(input int os);
    int w;
    w = $clog2(os * 4095 + (os >> 1) + 1);
    return (w < MV_W) ? MV_W : w;
  endfunction

endpackage

/* hdl/psc_if.sv */
// sample and result channel interfaces
interface psc_in_if;
  import psc_pkg::*;
  logic            valid;
  logic            ready;
  logic [FUNC_W-1:0] func;
  logic [MV_W-1:0] sample_mv;
  modport source (output valid, func, sample_mv, input ready);
  modport sink   (input valid, func, sample_mv, output ready);
endinterface

interface psc_out_if;
  import psc_pkg::*;
  logic                valid;
  logic                ready;
  logic [MV_W-1:0]     reading_mv;
  logic signed [PA_W-1:0] pressure_pa;
  logic [FAULT_W-1:0]  fault;
  logic [MV_W-1:0]     zero_level_mv;
  logic                is_bidirectional;
  logic                zero_updated;
  logic                zero_suspect;
  modport source (output valid, reading_mv, pressure_pa, fault, zero_level_mv,
                  is_bidirectional, zero_updated, zero_suspect, input ready);
  modport sink   (input valid, reading_mv, pressure_pa, fault, zero_level_mv,
                  is_bidirectional, zero_updated, zero_suspect, output ready);
endinterface

/* hdl/psc_div.sv */
// shared restoring divider, one quotient bit per cycle
module psc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [psc_pkg::DIV_NW-1:0]  n,
  input  logic [psc_pkg::DIV_DW-1:0]  dividend,
  input  logic [psc_pkg::DIV_SW-1:0]  divisor,
  output logic                        done,
  output logic [psc_pkg::DIV_DW-1:0]  quotient
);
  import psc_pkg::*;

  logic [DIV_DW-1:0] dvd;
  logic [DIV_SW:0]   rem;
  logic [DIV_SW-1:0] dsr;
  logic [DIV_NW-1:0] cnt;
  logic              busy;
  logic [DIV_SW:0]   shifted;
  logic [DIV_SW+1:0] trial;
  logic [DIV_NW-1:0] shamt;

  assign shifted  = {rem[DIV_SW-1:0], dvd[DIV_DW-1]};
  assign trial    = {1'b0, shifted} - {2'b00, dsr};
  assign shamt    = DIV_NW'(DIV_DW) - n;
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // align the significant bits of the dividend at the top
        dvd  <= dividend << shamt;
        rem  <= '0;
        dsr  <= divisor;
        cnt  <= n;
        busy <= 1'b1;
      end else if (busy) begin
        if (trial[DIV_SW+1]) begin
          rem <= shifted;
          dvd <= {dvd[DIV_DW-2:0], 1'b0};
        end else begin
          rem <= trial[DIV_SW:0];
          dvd <= {dvd[DIV_DW-2:0], 1'b1};
        end
        cnt <= cnt - 1'b1;
        if (cnt == DIV_NW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* hdl/psc_fifo.sv */
// short job queue between the front and back parts
module psc_fifo #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             valid
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [FW-1:0]    fill;
  logic             do_push;
  logic             do_pop;

  assign full    = (fill == FW'(DEPTH));
  assign valid   = (fill != '0);
  assign rdata   = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

/* hdl/psc_front.sv */
// front part: takes samples, builds oversample groups, queues jobs
module psc_front #(
  parameter int OVERSAMPLE = 16,
  parameter int SUMW = 16
) (
  input  logic                clk,
  input  logic                rst,
  psc_in_if.sink              samples,
  input  logic                full,
  output logic                push,
  output psc_pkg::func_t      push_func,
  output logic [SUMW-1:0]     push_value
);
  import psc_pkg::*;

  localparam int CNTW = $clog2(OVERSAMPLE + 1);
  localparam logic [CNTW-1:0] LAST = CNTW'(OVERSAMPLE - 1);

  logic [SUMW-1:0] sample_sum;
  logic [SUMW-1:0] sum_next;
  logic [CNTW-1:0] sample_count;
  logic            take;
  logic            group_end;
  func_t           func;

  assign samples.ready = !full;
  assign take          = samples.valid && samples.ready;
  assign func          = func_t'(samples.func);
  assign sum_next      = sample_sum + SUMW'(samples.sample_mv);
  assign group_end     = (sample_count == LAST);

  always_comb begin
    push       = 1'b0;
    push_func  = func;
    push_value = sum_next;
    case (func)
      FUNC_LOAD: begin
        push       = take;
        push_value = SUMW'(samples.sample_mv);
      end
      FUNC_MEASURE, FUNC_ZERO: push = take && group_end;
      default: push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum   <= '0;
      sample_count <= '0;
    end else if (take && (func == FUNC_MEASURE || func == FUNC_ZERO)) begin
      if (group_end) begin
        sample_sum   <= '0;
        sample_count <= '0;
      end else begin
        sample_sum   <= sum_next;
        sample_count <= sample_count + 1'b1;
      end
    end
  end

endmodule

/* hdl/psc_back.sv */
// back part: averaging, auto-zero, zero offset and pascal scaling
module psc_back #(
  parameter int OVERSAMPLE = 16,
  parameter int SUMW = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  job_valid,
  input  psc_pkg::func_t        job_func,
  input  logic [SUMW-1:0]       job_value,
  output logic                  job_pop,
  input  psc_pkg::cfg_t         cfg,
  input  psc_pkg::mode_load_t   mode,
  psc_out_if.source             results
);
  import psc_pkg::*;

  // group average by reciprocal multiplication, exact for any SUMW-bit sum
  localparam int OS_SH  = $clog2(OVERSAMPLE);
  localparam int AVG_K  = SUMW + OS_SH;
  localparam int AVG_MW = SUMW + 1;
  localparam int AVG_PW = SUMW + AVG_MW;
  localparam logic [AVG_MW-1:0] AVG_RECIP =
    AVG_MW'(((longint'(1) << AVG_K) + longint'(OVERSAMPLE) - 1) / longint'(OVERSAMPLE));
  localparam logic [SUMW-1:0] HALF_OS = SUMW'(OVERSAMPLE / 2);

  back_state_t       state, state_next;
  func_t             func_q;
  logic [SUMW-1:0]   value_q;
  logic [MV_W-1:0]   reading;
  fault_t            fault;
  logic [ZSUM_W-1:0] zero_sum;
  logic [ZCNT_W-1:0] zero_count;
  logic [MV_W-1:0]   zero_offset;
  logic              zero_known;
  logic              bidir_mode;
  logic              suspect;
  logic              updated;
  logic [MV_W-1:0]   ez;
  logic              neg;
  logic [PROD_W-1:0] prod1;
  logic [DEN_W-1:0]  den;
  logic [DIV_DW-1:0] mag;
  logic [PA_W-1:0]   pa;
  logic              out_valid;

  logic              div_start;
  logic [DIV_NW-1:0] div_n;
  logic [DIV_DW-1:0] div_dividend;
  logic [DIV_SW-1:0] div_divisor;
  logic              div_done;
  logic [DIV_DW-1:0] div_q;

  logic [AVG_PW-1:0]  avg_prod;
  logic [AVG_PW-1:0]  avg_q;
  logic [THEO_W-1:0]  theo_q;
  logic [THEO_PW-1:0] theo_prod;
  logic [THEO_PW-1:0] theo_z;

  logic [ZREAD_W:0]  zero_need;
  logic              zrun_done;
  logic [THEO_W-1:0] theo_num;
  logic [SUPPLY_W:0] half_supply;
  logic [MV_W:0]     diff;
  logic [MV_W-1:0]   abs_diff;
  logic [PCT_W-1:0]  p;
  logic [PCT_W-1:0]  s;
  logic [PA_W-1:0]   pa_mag;
  logic              out_free;

  psc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .n        (div_n),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign zero_need   = (cfg.zero_readings == '0) ? (ZREAD_W+1)'(1)
                                                  : {1'b0, cfg.zero_readings};
  assign zrun_done   = ({1'b0, zero_count} + 1'b1) >= zero_need;
  assign theo_num    = THEO_W'(cfg.supply_mv) * THEO_W'(PERMILLE - cfg.span_permille)
                       + THEO_ROUND;
  assign half_supply = ({1'b0, cfg.supply_mv} + 1'b1) >> 1;
  assign diff        = {1'b0, reading} - {1'b0, ez};
  assign abs_diff    = diff[MV_W] ? MV_W'(-diff) : diff[MV_W-1:0];
  assign p           = PCT_W'(zero_offset) * PCT_SCALE;
  assign s           = PCT_W'(cfg.supply_mv);
  assign pa_mag      = (div_q > PA_LIMIT) ? PA_W'(PA_LIMIT) : div_q[PA_W-1:0];
  assign out_free    = !out_valid || results.ready;
  assign avg_q       = avg_prod >> AVG_K;
  assign theo_prod   = THEO_PW'(theo_q) * THEO_PW'(THEO_RECIP);
  assign theo_z      = theo_prod >> THEO_SHIFT;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (job_valid) begin
          state_next = (job_func == FUNC_LOAD) ? ST_LOAD : ST_AVG_MUL;
        end
      end
      ST_LOAD:      state_next = ST_OUT;
      ST_AVG_MUL:   state_next = ST_AVG_SET;
      ST_AVG_SET:   state_next = ST_CHECK;
      ST_CHECK: begin
        if (func_q == FUNC_ZERO && zrun_done) state_next = ST_ZDIV_GO;
        else state_next = ST_EZ;
      end
      ST_ZDIV_GO:   state_next = ST_ZDIV_WAIT;
      ST_ZDIV_WAIT: if (div_done) state_next = ST_DETECT;
      ST_DETECT:    state_next = ST_EZ;
      ST_EZ: begin
        if (!zero_known && !bidir_mode && cfg.span_permille < PERMILLE) begin
          state_next = ST_THEO_NUM;
        end else begin
          state_next = ST_MUL1;
        end
      end
      ST_THEO_NUM:  state_next = ST_THEO_SET;
      ST_THEO_SET:  state_next = ST_MUL1;
      ST_MUL1:      state_next = ST_MUL2;
      ST_MUL2:      state_next = (den == '0) ? ST_OUT : ST_PDIV_GO;
      ST_PDIV_GO:   state_next = ST_PDIV_WAIT;
      ST_PDIV_WAIT: if (div_done) state_next = ST_OUT;
      ST_OUT:       if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    job_pop      = 1'b0;
    div_start    = 1'b0;
    div_n        = DIV_NW'(DIV_DW);
    div_dividend = mag + DIV_DW'(den >> 1);
    div_divisor  = den;
    case (state)
      ST_IDLE: job_pop = job_valid;
      ST_ZDIV_GO: begin
        div_start    = 1'b1;
        div_n        = DIV_NW'(ZSUM_W);
        div_dividend = DIV_DW'(zero_sum) + DIV_DW'(zero_count >> 1);
        div_divisor  = DIV_SW'(zero_count);
      end
      ST_PDIV_GO: div_start = 1'b1;
      default: div_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      zero_sum    <= '0;
      zero_count  <= '0;
      zero_offset <= '0;
      zero_known  <= 1'b0;
      bidir_mode  <= 1'b0;
    end else begin
      state <= state_next;
      if (mode.load) begin
        bidir_mode <= mode.value;
      end
      if (state == ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (job_valid) begin
            func_q  <= job_func;
            value_q <= job_value;
            updated <= 1'b0;
            suspect <= 1'b0;
          end
        end
        ST_LOAD: begin
          zero_offset <= value_q[MV_W-1:0];
          zero_known  <= 1'b1;
          zero_sum    <= '0;
          zero_count  <= '0;
          updated     <= 1'b1;
          reading     <= '0;
          fault       <= FAULT_OK;
          pa          <= '0;
          ez          <= value_q[MV_W-1:0];
        end
        ST_AVG_MUL: begin
          avg_prod <= AVG_PW'(value_q + HALF_OS) * AVG_PW'(AVG_RECIP);
        end
        ST_AVG_SET: begin
          reading <= (avg_q > AVG_PW'(MV_MAX)) ? MV_MAX : avg_q[MV_W-1:0];
        end
        ST_CHECK: begin
          if (reading < LOW_MV) begin
            fault <= FAULT_LOW;
          end else if ({2'b00, reading} + NEAR_SUPPLY_MV > {1'b0, cfg.supply_mv}) begin
            fault <= FAULT_HIGH;
          end else begin
            fault <= FAULT_OK;
          end
          if (func_q == FUNC_ZERO) begin
            zero_sum   <= zero_sum + ZSUM_W'(reading);
            zero_count <= zero_count + 1'b1;
          end
        end
        ST_ZDIV_WAIT: begin
          if (div_done) begin
            zero_offset <= (div_q > DIV_DW'(MV_MAX)) ? MV_MAX : div_q[MV_W-1:0];
            zero_known  <= 1'b1;
            zero_sum    <= '0;
            zero_count  <= '0;
            updated     <= 1'b1;
          end
        end
        ST_DETECT: begin
          if (cfg.auto_detect) begin
            bidir_mode <= p > PCT_BIDIR * s;
            suspect    <= (p < PCT_LOW * s)
                          || (p > PCT_BAND_LO * s && p < PCT_BAND_HI * s)
                          || (p > PCT_HIGH * s);
          end
        end
        ST_EZ: begin
          if (zero_known) begin
            ez <= zero_offset;
          end else if (bidir_mode) begin
            ez <= (half_supply > (SUPPLY_W+1)'(MV_MAX)) ? MV_MAX : half_supply[MV_W-1:0];
          end else begin
            // a span of the full supply or more puts the zero at ground
            ez <= '0;
          end
        end
        ST_THEO_NUM: begin
          theo_q <= theo_num;
        end
        ST_THEO_SET: begin
          ez <= (theo_z > THEO_PW'(MV_MAX)) ? MV_MAX : theo_z[MV_W-1:0];
        end
        ST_MUL1: begin
          neg   <= diff[MV_W];
          prod1 <= PROD_W'(abs_diff) * PROD_W'(cfg.full_scale_pa);
          den   <= DEN_W'(cfg.supply_mv) * DEN_W'(cfg.span_permille);
        end
        ST_MUL2: begin
          mag <= DIV_DW'(prod1) * DIV_DW'(bidir_mode ? SCALE_BI : SCALE_UNI);
          if (den == '0) begin
            pa <= '0;
          end
        end
        ST_PDIV_WAIT: begin
          if (div_done) begin
            pa <= neg ? (~pa_mag + 1'b1) : pa_mag;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            results.reading_mv       <= reading;
            results.pressure_pa      <= pa;
            results.fault            <= fault;
            results.zero_level_mv    <= ez;
            results.is_bidirectional <= bidir_mode;
            results.zero_updated     <= updated;
            results.zero_suspect     <= suspect;
          end
        end
        default: ;
      endcase
    end
  end

  assign results.valid = out_valid;

endmodule

/* hdl/pressure_sensor_conditioner.sv */
// pressure sensor conditioner top level: config registers, front, queue and back
// a sample that does not close a group is taken whenever the job queue has room
// a closed group runs through the back and divides on the shared bit-serial divider unless
// it has no divisor; a theoretical zero adds a multiply and an auto-zero run a divide
// a zero load sets the offset directly; a result held by the receiver stalls the back
// rst is synchronous: registers take their defaults, sums and counts clear
module pressure_sensor_conditioner #(
  parameter int OVERSAMPLE = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  psc_in_if.sink                         samples,
  psc_out_if.source                      results,
  input  logic                           cfg_we,
  input  logic [psc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [psc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import psc_pkg::*;

  localparam int SUMW = sum_width(OVERSAMPLE);
  localparam int JOBW = FUNC_W + SUMW;

  cfg_t            cfg;
  mode_load_t      mode;

  logic            push;
  func_t           push_func;
  logic [SUMW-1:0] push_value;
  logic            full;
  logic            job_valid;
  logic            job_pop;
  logic [JOBW-1:0] job_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.supply_mv     <= 13'd3300;
      cfg.span_permille <= 10'd800;
      cfg.full_scale_pa <= 20'd40000;
      cfg.auto_detect   <= 1'b0;
      cfg.zero_readings <= 16'd256;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_SUPPLY:        cfg.supply_mv     <= cfg_data[SUPPLY_W-1:0];
        REG_SPAN:          cfg.span_permille <= cfg_data[SPAN_W-1:0];
        REG_FULL_SCALE:    cfg.full_scale_pa <= cfg_data[FS_W-1:0];
        REG_AUTO_DETECT:   cfg.auto_detect   <= cfg_data[0];
        REG_ZERO_READINGS: cfg.zero_readings <= cfg_data[ZREAD_W-1:0];
        default: ;
      endcase
    end
  end

  // writing the default mode only sets the live mode held in the back part
  assign mode.load  = cfg_we && (reg_idx_t'(cfg_index) == REG_BIDIR);
  assign mode.value = cfg_data[0];

  psc_front #(
    .OVERSAMPLE (OVERSAMPLE),
    .SUMW       (SUMW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .samples    (samples),
    .full       (full),
    .push       (push),
    .push_func  (push_func),
    .push_value (push_value)
  );

  psc_fifo #(
    .WIDTH (JOBW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata ({push_func, push_value}),
    .full  (full),
    .pop   (job_pop),
    .rdata (job_data),
    .valid (job_valid)
  );

  psc_back #(
    .OVERSAMPLE (OVERSAMPLE),
    .SUMW       (SUMW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_func  (func_t'(job_data[JOBW-1 -: FUNC_W])),
    .job_value (job_data[SUMW-1:0]),
    .job_pop   (job_pop),
    .cfg       (cfg),
    .mode      (mode),
    .results   (results)
  );

endmodule
